>>> rtl/lsch_pkg.sv
// ----------------------------------------------------------------------------
// lottery scheduler package
// shared sizes, operation and status codes, controller command struct
// ----------------------------------------------------------------------------
package lsch_pkg;

  localparam int MaxTasks  = 16;
  localparam int IdxW      = $clog2(MaxTasks);
  localparam int CntW      = $clog2(MaxTasks + 1);
  localparam int IdW       = 22;
  localparam int TixW      = 16;
  localparam int TotW      = 20;
  localparam int RndW      = 32;
  localparam int DrawW     = 31;

  localparam logic [TotW-1:0] TotalMax = 20'hFFFFF;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_TICK       = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_NOT_FOUND  = 2'd2,
    ST_NO_TICKETS = 2'd3
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // capture request fields
    logic do_register; // append entry
    logic mod_init;    // start remainder unit
    logic mod_step;    // one remainder bit
    logic walk_init;   // start walk at newest entry
    logic walk_step;   // examine one entry
    logic shift_step;  // move one entry down after a removal
    logic finish;      // build result
  } cmd_t;

  // status back to controller
  typedef struct packed {
    logic    mod_done;
    logic    walk_done;
    logic    shift_done;
    logic    found;
    logic    reg_ok;
    logic    total_zero;
    op_t     op;
  } sts_t;

endpackage

>>> rtl/lsch_datapath.sv
// ----------------------------------------------------------------------------
// lottery scheduler datapath
// task table, running total, bit-serial remainder and entry walk
// ----------------------------------------------------------------------------
module lsch_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  lsch_pkg::cmd_t          cmd,
  output lsch_pkg::sts_t          sts,
  input  logic [1:0]              operation_in,
  input  logic [lsch_pkg::IdW-1:0]  task_id_in,
  input  logic [lsch_pkg::TixW-1:0] ticket_count_in,
  input  logic [lsch_pkg::RndW-1:0] random_value_in,
  output logic [1:0]              status,
  output logic                    winner_valid,
  output logic [lsch_pkg::IdW-1:0]  winner_id,
  output logic                    demoted_valid,
  output logic [lsch_pkg::IdW-1:0]  demoted_id,
  output logic [lsch_pkg::TotW-1:0] total_tickets
);
  import lsch_pkg::*;

  logic [IdW-1:0]  id_table     [MaxTasks];
  logic [TixW-1:0] ticket_table [MaxTasks];
  logic [CntW-1:0] entry_count;
  logic [TotW-1:0] ticket_total;
  logic [IdxW-1:0] running_index;
  logic            running_valid;

  op_t             op;
  logic [IdW-1:0]  tid;
  logic [TixW-1:0] tix;
  logic [DrawW-1:0] dividend;
  logic [TotW:0]   rem;
  logic [4:0]      mod_cnt;

  logic [CntW-1:0] k;       // walk position plus one
  logic [TotW:0]   acc;
  logic [IdxW-1:0] pick;
  logic            hit;     // entry matched, or register request taken
  logic            walk_done;
  logic [CntW-1:0] sh;      // shift position

  logic [IdxW-1:0] k_idx;
  logic [TotW:0]   rem_sh;
  logic [TotW:0]   acc_add;
  logic [TotW:0]   reg_sum;

  assign k_idx   = IdxW'(k - CntW'(1));
  assign rem_sh  = {rem[TotW-1:0], dividend[DrawW-1]};
  assign acc_add = acc + (TotW+1)'(ticket_table[k_idx]);
  assign reg_sum = {1'b0, ticket_total} + (TotW+1)'(tix);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= op_t'(operation_in);
      tid <= task_id_in;
      tix <= ticket_count_in;
      dividend <= random_value_in[DrawW-1:0];
    end
    // restoring remainder, one bit a step
    if (cmd.mod_init) begin
      rem <= '0;
      mod_cnt <= '0;
    end else if (cmd.mod_step) begin
      dividend <= {dividend[DrawW-2:0], 1'b0};
      mod_cnt  <= mod_cnt + 5'd1;
      if (rem_sh >= {1'b0, ticket_total}) rem <= rem_sh - {1'b0, ticket_total};
      else rem <= rem_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      ticket_total  <= '0;
      running_index <= '0;
      running_valid <= 1'b0;
      walk_done     <= 1'b0;
      hit           <= 1'b0;
      k             <= '0;
      sh            <= '0;
      status        <= ST_OK;
      winner_valid  <= 1'b0;
      winner_id     <= '0;
      demoted_valid <= 1'b0;
      demoted_id    <= '0;
      total_tickets <= '0;
      acc           <= '0;
      pick          <= '0;
    end else begin
      if (cmd.load) hit <= 1'b0;
      if (cmd.do_register) begin
        id_table[IdxW'(entry_count)]     <= tid;
        ticket_table[IdxW'(entry_count)] <= tix;
        entry_count  <= entry_count + CntW'(1);
        ticket_total <= reg_sum[TotW-1:0];
        hit          <= 1'b1;
      end
      if (cmd.walk_init) begin
        k         <= entry_count;
        acc       <= '0;
        hit       <= 1'b0;
        walk_done <= (entry_count == '0);
      end else if (cmd.walk_step && !walk_done) begin
        if (op == OP_TICK) begin
          acc  <= acc_add;
          pick <= k_idx;
          if (acc_add > rem) walk_done <= 1'b1;
        end else if (id_table[k_idx] == tid) begin
          hit       <= 1'b1;
          pick      <= k_idx;
          walk_done <= 1'b1;
          sh        <= {1'b0, k_idx};
          ticket_total <= ticket_total - TotW'(ticket_table[k_idx]);
        end
        if (k == CntW'(1)) walk_done <= 1'b1;
        k <= k - CntW'(1);
      end
      if (cmd.shift_step) begin
        if (sh + CntW'(1) < entry_count) begin
          id_table[IdxW'(sh)]     <= id_table[IdxW'(sh + CntW'(1))];
          ticket_table[IdxW'(sh)] <= ticket_table[IdxW'(sh + CntW'(1))];
          sh <= sh + CntW'(1);
        end else begin
          entry_count   <= entry_count - CntW'(1);
          running_valid <= 1'b0;
          running_index <= '0;
          sh            <= entry_count;
        end
      end
      if (cmd.finish) begin
        winner_valid  <= 1'b0;
        winner_id     <= '0;
        demoted_valid <= 1'b0;
        demoted_id    <= '0;
        status        <= ST_OK;
        case (op)
          OP_REGISTER:   if (!hit) status <= ST_FULL;
          OP_UNREGISTER: if (!hit) status <= ST_NOT_FOUND;
          OP_TICK: begin
            if (ticket_total == '0) begin
              status <= ST_NO_TICKETS;
            end else begin
              if (running_valid && CntW'(running_index) < entry_count) begin
                demoted_valid <= 1'b1;
                demoted_id    <= id_table[running_index];
              end
              running_index <= pick;
              running_valid <= 1'b1;
              winner_valid  <= 1'b1;
              winner_id     <= id_table[pick];
            end
          end
          default: ;
        endcase
        total_tickets <= ticket_total;
      end
    end
  end

  assign sts.mod_done   = (mod_cnt == 5'(DrawW));
  assign sts.walk_done  = walk_done;
  assign sts.shift_done = (sh == entry_count) || (sh + CntW'(1) >= entry_count);
  assign sts.found      = hit;
  assign sts.reg_ok     = (entry_count < CntW'(MaxTasks)) && (reg_sum <= {1'b0, TotalMax});
  assign sts.total_zero = (ticket_total == '0);
  assign sts.op         = op;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CntW'(MaxTasks)) else $error("entry count beyond table");
  a_winner_running: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && op == OP_TICK && ticket_total != '0 |=> running_valid && winner_valid)
    else $error("tick winner not made running");
  a_remainder_bound: assert property (@(posedge clk) disable iff (rst)
    sts.mod_done && !sts.total_zero |-> rem < {1'b0, ticket_total})
    else $error("remainder not below total");

endmodule

>>> rtl/lsch_ctrl.sv
// ----------------------------------------------------------------------------
// lottery scheduler controller
// sequences register, unregister and tick requests over the datapath
// ----------------------------------------------------------------------------
module lsch_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output lsch_pkg::cmd_t cmd,
  input  lsch_pkg::sts_t sts
);
  import lsch_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEC   = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_WALKI = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_SHIFT = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    done_next  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cmd.mod_init = 1'b1;
        case (sts.op)
          OP_REGISTER: begin
            cmd.do_register = sts.reg_ok;
            state_next = S_FIN;
          end
          OP_UNREGISTER: state_next = S_WALKI;
          OP_TICK:       state_next = sts.total_zero ? S_FIN : S_MOD;
          default:       state_next = S_FIN;
        endcase
      end
      S_MOD: begin
        if (sts.mod_done) state_next = S_WALKI;
        else cmd.mod_step = 1'b1;
      end
      S_WALKI: begin
        cmd.walk_init = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (sts.walk_done) begin
          state_next = (sts.op == OP_UNREGISTER && sts.found) ? S_SHIFT : S_FIN;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.shift_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |=> done && state == S_IDLE) else $error("missing done");
  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.do_register, cmd.mod_step, cmd.walk_step, cmd.shift_step, cmd.finish}))
    else $error("conflicting commands");

endmodule

>>> rtl/lottery_scheduler_unit.sv
// ----------------------------------------------------------------------------
// lottery scheduler unit
// table of up to sixteen tasks with ticket counts and a lottery draw per tick
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy low; one result follows,
// shown for a single cycle with done high, and the receiver cannot stall it.
// a register request is decoded and then finished. an unregister request
// searches the table entry by entry (newest first); when the id is found,
// the entries above it are then moved down one place. a tick with no
// tickets is finished straight after decoding; otherwise the 31-bit draw
// is reduced modulo the ticket total by a bit-serial remainder unit, one
// bit per cycle, then the table is walked one entry per cycle. busy falls
// in the done cycle, so the next request can be taken there.
module lottery_scheduler_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  output logic                        done,
  input  logic [1:0]                  operation,
  input  logic [lsch_pkg::IdW-1:0]    task_id,
  input  logic [lsch_pkg::TixW-1:0]   ticket_count,
  input  logic [lsch_pkg::RndW-1:0]   random_value,
  output logic [1:0]                  status,
  output logic                        winner_valid,
  output logic [lsch_pkg::IdW-1:0]    winner_id,
  output logic                        demoted_valid,
  output logic [lsch_pkg::IdW-1:0]    demoted_id,
  output logic [lsch_pkg::TotW-1:0]   total_tickets
);
  import lsch_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller: request sequencing
  lsch_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .cmd  (cmd),
    .sts  (sts)
  );

  // datapath: table, totals, remainder and walk
  lsch_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .operation_in   (operation),
    .task_id_in     (task_id),
    .ticket_count_in(ticket_count),
    .random_value_in(random_value),
    .status         (status),
    .winner_valid   (winner_valid),
    .winner_id      (winner_id),
    .demoted_valid  (demoted_valid),
    .demoted_id     (demoted_id),
    .total_tickets  (total_tickets)
  );

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// lottery scheduler unit testbench
// drives register, unregister and tick requests through the start/busy
// handshake and checks every result against a cycle-free prediction of the
// task table, ticket total and running task
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsch_pkg::*;

  localparam int CycleLimit = 900000;
  localparam int Requests   = 1100;

  // one result as the block presents it
  typedef struct {
    status_t        st;
    logic           win_v;
    logic [IdW-1:0] win_id;
    logic           dem_v;
    logic [IdW-1:0] dem_id;
    logic [TotW-1:0] total;
  } outcome_t;

  // predicted scheduler state and the results still owed by the block
  class sched_board;
    logic [IdW-1:0]  ids[MaxTasks];
    logic [TixW-1:0] tix[MaxTasks];
    int              n_entries;
    logic [TotW-1:0] total;
    int              run_idx;
    bit              run_v;
    outcome_t        owed[$];
    int              errors;

    function void clear();
      n_entries = 0;
      total     = '0;
      run_idx   = 0;
      run_v     = 0;
      errors    = 0;
    endfunction

    // work out the result of an accepted request and queue it
    function void note_request(op_t op, logic [IdW-1:0] id, logic [TixW-1:0] tk,
                               logic [RndW-1:0] rnd);
      outcome_t o;
      int k;
      bit hit;
      logic [31:0] draw, acc;
      o = '{ST_OK, 0, '0, 0, '0, '0};
      case (op)
        OP_REGISTER: begin
          if (n_entries >= MaxTasks || 32'(total) + 32'(tk) > 32'(TotalMax)) begin
            o.st = ST_FULL;
          end else begin
            ids[n_entries] = id;
            tix[n_entries] = tk;
            n_entries++;
            total += tk;
          end
        end
        OP_UNREGISTER: begin
          hit = 0;
          // newest matching entry goes first
          for (k = n_entries - 1; k >= 0; k--) begin
            if (ids[k] == id) begin
              hit = 1;
              break;
            end
          end
          if (!hit) begin
            o.st = ST_NOT_FOUND;
          end else begin
            total -= tix[k];
            for (int j = k; j + 1 < n_entries; j++) begin
              ids[j] = ids[j+1];
              tix[j] = tix[j+1];
            end
            n_entries--;
            run_v   = 0;
            run_idx = 0;
          end
        end
        OP_TICK: begin
          if (total == 0) begin
            o.st = ST_NO_TICKETS;
          end else begin
            draw = {1'b0, rnd[DrawW-1:0]} % 32'(total);
            acc  = 0;
            k    = 0;
            for (int j = n_entries - 1; j >= 0; j--) begin
              acc += tix[j];
              k = j;
              if (acc > draw) break;
            end
            if (run_v && run_idx < n_entries) begin
              o.dem_v  = 1;
              o.dem_id = ids[run_idx];
            end
            run_idx  = k;
            run_v    = 1;
            o.win_v  = 1;
            o.win_id = ids[k];
          end
        end
        default: ;
      endcase
      o.total = total;
      owed.push_back(o);
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
        return 0;
      end
      return 1;
    endfunction

    function void check_result(outcome_t a);
      outcome_t e;
      bit ok;
      if (owed.size() == 0) begin
        $display("%0t unexpected result: status %0d total %0h", $time, a.st, a.total);
        errors++;
        return;
      end
      e = owed.pop_front();
      ok = field_ok("status", e.st, a.st);
      ok &= field_ok("winner_valid", e.win_v, a.win_v);
      ok &= field_ok("winner_id", e.win_id, a.win_id);
      ok &= field_ok("demoted_valid", e.dem_v, a.dem_v);
      ok &= field_ok("demoted_id", e.dem_id, a.dem_id);
      ok &= field_ok("total_tickets", e.total, a.total);
      if (!ok) errors++;
    endfunction

    // id of a live entry, so that removals usually find something
    function logic [IdW-1:0] live_id();
      if (n_entries == 0) return IdW'($urandom_range(0, 7));
      return ids[$urandom_range(0, n_entries - 1)];
    endfunction
  endclass

  logic            clk = 0;
  logic            rst;
  logic            start;
  logic            busy;
  logic            done;
  logic [1:0]      operation;
  logic [IdW-1:0]  task_id;
  logic [TixW-1:0] ticket_count;
  logic [RndW-1:0] random_value;
  logic [1:0]      status;
  logic            winner_valid;
  logic [IdW-1:0]  winner_id;
  logic            demoted_valid;
  logic [IdW-1:0]  demoted_id;
  logic [TotW-1:0] total_tickets;

  sched_board board = new();
  int cycles = 0;
  int idle_pct;

  lottery_scheduler_unit dut (
    .clk, .rst, .start, .busy, .done, .operation, .task_id, .ticket_count,
    .random_value, .status, .winner_valid, .winner_id, .demoted_valid,
    .demoted_id, .total_tickets
  );

  always #5 clk = ~clk;

  // every result is shown for one cycle only, so sample each strobe
  always @(posedge clk) begin
    if (!rst && done) begin
      board.check_result('{status_t'(status), winner_valid, winner_id,
                           demoted_valid, demoted_id, total_tickets});
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // present one request and hold it until the block takes it; start stays
  // high afterwards, unless a sender gap follows, so back-to-back requests need no extra edge
  task automatic send_request(op_t op, logic [IdW-1:0] id, logic [TixW-1:0] tk,
                              logic [RndW-1:0] rnd);
    start        <= 1'b1;
    operation    <= op;
    task_id      <= id;
    ticket_count <= tk;
    random_value <= rnd;
    do @(posedge clk); while (busy);
    board.note_request(op, id, tk, rnd);
    // random sender gaps, the length varied so they land on every phase
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
  endtask

  // wait until the block has handed back everything owed
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (board.owed.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [TixW-1:0] pick_tickets();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return TixW'($urandom);
      default: return TixW'($urandom_range(1, 100));
    endcase
  endfunction

  function automatic logic [IdW-1:0] pick_id();
    if ($urandom_range(0, 4) == 0) return IdW'($urandom);
    return IdW'($urandom_range(0, 11));
  endfunction

  initial begin
    op_t op;
    int phase_len;
    board.clear();
    rst          <= 1'b1;
    start        <= 1'b0;
    operation    <= OP_REGISTER;
    task_id      <= '0;
    ticket_count <= '0;
    random_value <= '0;
    idle_pct     = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, zero-ticket task, extremes, same task winning
    // again, filling to full, duplicate removal, unknown id, unused opcode
    send_request(OP_TICK, '0, '0, '1);
    send_request(OP_UNREGISTER, 22'h15, '0, '0);
    send_request(OP_REGISTER, '0, '0, '0);
    send_request(OP_TICK, '0, '0, 32'h1234);
    send_request(OP_REGISTER, '1, '1, '0);
    send_request(OP_TICK, '0, '0, '1);
    send_request(OP_TICK, '0, '0, '0);
    send_request(OP_TICK, '0, '0, 32'h8000_0000);
    for (int k = 0; k < 14; k++) begin
      send_request(OP_REGISTER, IdW'(k % 4 + 1), (k == 13) ? '1 : TixW'(k * 7), '0);
    end
    send_request(OP_REGISTER, 22'h2aaaaa, 16'h5555, '0);
    send_request(OP_TICK, '0, '0, 32'h7fff_ffff);
    send_request(OP_UNREGISTER, 22'h2, '0, '0);
    send_request(OP_UNREGISTER, 22'h155555, '0, '0);
    send_request(OP_NONE, '1, '1, '1);
    send_request(OP_TICK, '0, '0, 32'h5555_5555);
    drain();

    // random part in four phases with different idle rates, drained between them
    phase_len = Requests / 4;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 64 : (ph == 3) ? 9 : 0;
      for (int i = 0; i < phase_len; i++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: op = OP_REGISTER;
          9, 10, 11, 12, 13:         op = OP_UNREGISTER;
          19:                        op = OP_NONE;
          default:                   op = OP_TICK;
        endcase
        // fill-heavy and drain-heavy stretches so full and empty both occur
        if ((i / 40) % 3 == 2 && op == OP_REGISTER) op = OP_UNREGISTER;
        send_request(op,
                     (op == OP_UNREGISTER && $urandom_range(0, 5) != 0) ?
                       board.live_id() : pick_id(),
                     pick_tickets(), $urandom);
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
